/* design/stt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Token kinds, character codes and result types shared by the tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int KIND_BITS = 6;
  localparam int OUT_POS_BITS = 16;

  // token kinds
  localparam logic [KIND_BITS-1:0] K_WS        = 6'd0;
  localparam logic [KIND_BITS-1:0] K_LBRACE    = 6'd1;
  localparam logic [KIND_BITS-1:0] K_RBRACE    = 6'd2;
  localparam logic [KIND_BITS-1:0] K_LPAREN    = 6'd3;
  localparam logic [KIND_BITS-1:0] K_RPAREN    = 6'd4;
  localparam logic [KIND_BITS-1:0] K_LBRACKET  = 6'd5;
  localparam logic [KIND_BITS-1:0] K_RBRACKET  = 6'd6;
  localparam logic [KIND_BITS-1:0] K_COLON     = 6'd7;
  localparam logic [KIND_BITS-1:0] K_SEMI      = 6'd8;
  localparam logic [KIND_BITS-1:0] K_COMMA     = 6'd9;
  localparam logic [KIND_BITS-1:0] K_ASSIGN    = 6'd10;
  localparam logic [KIND_BITS-1:0] K_PLUS      = 6'd11;
  localparam logic [KIND_BITS-1:0] K_MINUS     = 6'd12;
  localparam logic [KIND_BITS-1:0] K_STAR      = 6'd13;
  localparam logic [KIND_BITS-1:0] K_SLASH     = 6'd14;
  localparam logic [KIND_BITS-1:0] K_DOT       = 6'd15;
  localparam logic [KIND_BITS-1:0] K_LT        = 6'd16;
  localparam logic [KIND_BITS-1:0] K_GT        = 6'd17;
  localparam logic [KIND_BITS-1:0] K_LE        = 6'd18;
  localparam logic [KIND_BITS-1:0] K_GE        = 6'd19;
  localparam logic [KIND_BITS-1:0] K_EQ        = 6'd20;
  localparam logic [KIND_BITS-1:0] K_NE        = 6'd21;
  localparam logic [KIND_BITS-1:0] K_ANDAND    = 6'd22;
  localparam logic [KIND_BITS-1:0] K_OROR      = 6'd23;
  localparam logic [KIND_BITS-1:0] K_AMP       = 6'd24;
  localparam logic [KIND_BITS-1:0] K_BAR       = 6'd25;
  localparam logic [KIND_BITS-1:0] K_BANG      = 6'd26;
  localparam logic [KIND_BITS-1:0] K_QUESTION  = 6'd27;
  localparam logic [KIND_BITS-1:0] K_NUMBER    = 6'd28;
  localparam logic [KIND_BITS-1:0] K_LABEL     = 6'd29;
  localparam logic [KIND_BITS-1:0] K_CHARACTER = 6'd30;
  localparam logic [KIND_BITS-1:0] K_STRING    = 6'd31;
  localparam logic [KIND_BITS-1:0] K_COMMENT   = 6'd32;
  localparam logic [KIND_BITS-1:0] K_UNDEF     = 6'd33;
  localparam logic [KIND_BITS-1:0] K_END       = 6'd34;

  // character codes
  localparam logic [7:0] CH_EQUALS    = 8'h3D;
  localparam logic [7:0] CH_AMP       = 8'h26;
  localparam logic [7:0] CH_BAR       = 8'h7C;
  localparam logic [7:0] CH_POINT     = 8'h2E;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_UNDER     = 8'h5F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;

  typedef struct packed {
    logic [KIND_BITS-1:0]    token_kind;
    logic [OUT_POS_BITS-1:0] start_position;
    logic                    run_last;
  } result_t;

  // results from one accepted item, packed from slot 0
  typedef struct packed {
    logic [1:0]    count;
    result_t [2:0] item;
  } push_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_label(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

endpackage

/* design/stt_lexer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_lexer
// Lexer state and the per-byte step; yields up to three results per transfer.
// ----------------------------------------------------------------------------
module stt_lexer import stt_pkg::*; #(
  parameter int POS_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] text_byte,
  input  logic       is_last,
  input  logic       end_only,
  output push_t      push
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_DONE    = 4'd1;
  localparam logic [3:0] M_PAIR    = 4'd2;
  localparam logic [3:0] M_SLASH   = 4'd3;
  localparam logic [3:0] M_COMMENT = 4'd4;
  localparam logic [3:0] M_WS      = 4'd5;
  localparam logic [3:0] M_LABEL   = 4'd6;
  localparam logic [3:0] M_NUMBER  = 4'd7;
  localparam logic [3:0] M_UNDEF   = 4'd8;
  localparam logic [3:0] M_CHAR    = 4'd9;
  localparam logic [3:0] M_STRING  = 4'd10;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  logic [3:0]           lexer_mode, lexer_mode_next;
  logic [KIND_BITS-1:0] open_kind, open_kind_next;
  logic [POS_BITS-1:0]  open_start, open_start_next;
  logic [POS_BITS-1:0]  byte_position, byte_position_next;
  logic                 point_seen, point_seen_next;
  logic                 previous_was_point, previous_was_point_next;
  logic                 escape_active, escape_active_next;
  logic [1:0]           quote_char_phase, quote_char_phase_next;

  logic          absorbed;
  logic [7:0]    want;
  logic [1:0]    slot;
  result_t [2:0] items;

  always_comb begin
    lexer_mode_next         = lexer_mode;
    open_kind_next          = open_kind;
    open_start_next         = open_start;
    byte_position_next      = byte_position;
    point_seen_next         = point_seen;
    previous_was_point_next = previous_was_point;
    escape_active_next      = escape_active;
    quote_char_phase_next   = quote_char_phase;
    absorbed                = 1'b0;
    want                    = CH_EQUALS;
    slot                    = 2'd0;
    items                   = '0;

    if (!end_only) begin
      case (lexer_mode)
        M_PAIR: begin
          if (open_kind == K_AMP) want = CH_AMP;
          else if (open_kind == K_BAR) want = CH_BAR;
          if (text_byte == want) begin
            absorbed        = 1'b1;
            lexer_mode_next = M_DONE;
            case (open_kind)
              K_BANG:   open_kind_next = K_NE;
              K_ASSIGN: open_kind_next = K_EQ;
              K_LT:     open_kind_next = K_LE;
              K_GT:     open_kind_next = K_GE;
              K_AMP:    open_kind_next = K_ANDAND;
              default:  open_kind_next = K_OROR;
            endcase
          end
        end
        M_SLASH: begin
          if (text_byte == CH_SLASH) begin
            absorbed        = 1'b1;
            open_kind_next  = K_COMMENT;
            lexer_mode_next = M_COMMENT;
          end
        end
        M_COMMENT: absorbed = (text_byte != CH_LF);
        M_WS:      absorbed = is_ws(text_byte);
        M_LABEL:   absorbed = is_label(text_byte);
        M_UNDEF:   absorbed = !is_ws(text_byte);
        M_NUMBER: begin
          if (text_byte == CH_POINT) begin
            absorbed = 1'b1;
            if (point_seen) begin
              open_kind_next  = K_UNDEF;
              lexer_mode_next = M_UNDEF;
            end else begin
              point_seen_next         = 1'b1;
              previous_was_point_next = 1'b1;
            end
          end else if (is_digit(text_byte)) begin
            absorbed                = 1'b1;
            previous_was_point_next = 1'b0;
          end else if (point_seen && previous_was_point) begin
            // anything but a digit straight after the point spoils the number
            absorbed        = 1'b1;
            open_kind_next  = K_UNDEF;
            lexer_mode_next = M_UNDEF;
          end
        end
        M_CHAR: begin
          absorbed = 1'b1;
          if (quote_char_phase == 2'd1) begin
            quote_char_phase_next = (text_byte == CH_BACKSLASH) ? 2'd2 : 2'd3;
          end else if (quote_char_phase == 2'd2) begin
            quote_char_phase_next = 2'd3;
          end else begin
            open_kind_next        = (text_byte == CH_QUOTE) ? K_CHARACTER : K_UNDEF;
            quote_char_phase_next = 2'd0;
            lexer_mode_next       = M_DONE;
          end
        end
        M_STRING: begin
          absorbed = 1'b1;
          if (text_byte == CH_DQUOTE) begin
            if (!escape_active) begin
              open_kind_next  = K_STRING;
              lexer_mode_next = M_DONE;
            end else begin
              escape_active_next = 1'b0;
            end
          end else if (text_byte == CH_BACKSLASH) begin
            escape_active_next = !escape_active;
          end else begin
            escape_active_next = 1'b0;
          end
        end
        default: absorbed = 1'b0;
      endcase

      if (!absorbed) begin
        // close the open token and start a new one at this byte
        if (lexer_mode != M_IDLE) begin
          items[slot].token_kind     = open_kind;
          items[slot].start_position = OUT_POS_BITS'(open_start);
          slot                       = slot + 2'd1;
        end
        open_start_next         = byte_position;
        point_seen_next         = 1'b0;
        previous_was_point_next = 1'b0;
        escape_active_next      = 1'b0;
        quote_char_phase_next   = 2'd0;
        lexer_mode_next         = M_DONE;
        case (text_byte)
          8'h7B: open_kind_next = K_LBRACE;
          8'h7D: open_kind_next = K_RBRACE;
          8'h28: open_kind_next = K_LPAREN;
          8'h29: open_kind_next = K_RPAREN;
          8'h5B: open_kind_next = K_LBRACKET;
          8'h5D: open_kind_next = K_RBRACKET;
          8'h3A: open_kind_next = K_COLON;
          8'h3B: open_kind_next = K_SEMI;
          8'h2C: open_kind_next = K_COMMA;
          8'h2B: open_kind_next = K_PLUS;
          8'h2D: open_kind_next = K_MINUS;
          8'h2A: open_kind_next = K_STAR;
          CH_POINT: open_kind_next = K_DOT;
          8'h3F: open_kind_next = K_QUESTION;
          CH_EQUALS: begin
            open_kind_next  = K_ASSIGN;
            lexer_mode_next = M_PAIR;
          end
          8'h3C: begin
            open_kind_next  = K_LT;
            lexer_mode_next = M_PAIR;
          end
          8'h3E: begin
            open_kind_next  = K_GT;
            lexer_mode_next = M_PAIR;
          end
          CH_AMP: begin
            open_kind_next  = K_AMP;
            lexer_mode_next = M_PAIR;
          end
          CH_BAR: begin
            open_kind_next  = K_BAR;
            lexer_mode_next = M_PAIR;
          end
          8'h21: begin
            open_kind_next  = K_BANG;
            lexer_mode_next = M_PAIR;
          end
          CH_SLASH: begin
            open_kind_next  = K_SLASH;
            lexer_mode_next = M_SLASH;
          end
          CH_QUOTE: begin
            open_kind_next        = K_UNDEF;
            lexer_mode_next       = M_CHAR;
            quote_char_phase_next = 2'd1;
          end
          CH_DQUOTE: begin
            open_kind_next  = K_UNDEF;
            lexer_mode_next = M_STRING;
          end
          default: begin
            if (is_alpha(text_byte)) begin
              open_kind_next  = K_LABEL;
              lexer_mode_next = M_LABEL;
            end else if (is_ws(text_byte)) begin
              open_kind_next  = K_WS;
              lexer_mode_next = M_WS;
            end else if (is_digit(text_byte)) begin
              open_kind_next  = K_NUMBER;
              lexer_mode_next = M_NUMBER;
            end else begin
              open_kind_next  = K_UNDEF;
              lexer_mode_next = M_UNDEF;
            end
          end
        endcase
      end

      if (byte_position != POS_MAX) byte_position_next = byte_position + POS_BITS'(1);
    end

    if (end_only || is_last) begin
      // flush the open token, then END at the text length, and start afresh
      if (lexer_mode_next != M_IDLE) begin
        items[slot].token_kind     = open_kind_next;
        items[slot].start_position = OUT_POS_BITS'(open_start_next);
        slot                       = slot + 2'd1;
      end
      items[slot].token_kind     = K_END;
      items[slot].start_position = OUT_POS_BITS'(byte_position_next);
      slot                       = slot + 2'd1;
      lexer_mode_next         = M_IDLE;
      open_kind_next          = '0;
      open_start_next         = '0;
      byte_position_next      = '0;
      point_seen_next         = 1'b0;
      previous_was_point_next = 1'b0;
      escape_active_next      = 1'b0;
      quote_char_phase_next   = 2'd0;
    end

    if (slot != 2'd0) items[slot - 2'd1].run_last = 1'b1;

    push.item  = items;
    push.count = take ? slot : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lexer_mode         <= M_IDLE;
      open_kind          <= '0;
      open_start         <= '0;
      byte_position      <= '0;
      point_seen         <= 1'b0;
      previous_was_point <= 1'b0;
      escape_active      <= 1'b0;
      quote_char_phase   <= 2'd0;
    end else if (take) begin
      lexer_mode         <= lexer_mode_next;
      open_kind          <= open_kind_next;
      open_start         <= open_start_next;
      byte_position      <= byte_position_next;
      point_seen         <= point_seen_next;
      previous_was_point <= previous_was_point_next;
      escape_active      <= escape_active_next;
      quote_char_phase   <= quote_char_phase_next;
    end
  end

endmodule

/* design/stt_result_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_result_queue
// Four-entry result queue: takes up to three results a cycle, sends one unless out_stall holds it.
// ----------------------------------------------------------------------------
module stt_result_queue import stt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t head
);

  result_t    entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rd_ptr];
  // one item can bring three results, so keep three slots free
  assign room      = (count <= 3'd1);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push.count) entries[wr_ptr + 2'(i)] <= push.item[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push.count) - 3'(pop);
    end
  end

endmodule

/* design/script_text_tokenizer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_text_tokenizer_top
// Streaming lexer: one text byte per transfer in, tokens out as they close.
// ----------------------------------------------------------------------------
// A result is written into the result queue at the transfer that closes it, and offered from the queue head.
// Throughput: one byte per cycle; an item yielding several results, or a
//   stalled output, holds the input for as many output transfers as the queue needs to drain.
// The input is taken while the four-entry result queue holds at most one entry.
// Reset (rst, synchronous) empties the queue and returns the lexer to idle.
module script_text_tokenizer_top import stt_pkg::*; #(
  parameter int POS_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              text_byte,
  input  logic                    is_last,
  input  logic                    end_only,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [KIND_BITS-1:0]    token_kind,
  output logic [OUT_POS_BITS-1:0] start_position,
  output logic                    run_last
);

  push_t   push;
  result_t head;
  logic    room;
  logic    take;

  assign in_stall = !room;
  assign take     = in_valid && room;

  stt_lexer #(
    .POS_BITS(POS_BITS)
  ) u_lexer (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .text_byte (text_byte),
    .is_last   (is_last),
    .end_only  (end_only),
    .push      (push)
  );

  stt_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign token_kind     = head.token_kind;
  assign start_position = head.start_position;
  assign run_last       = head.run_last;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the script text tokenizer. A short table of texts
// exercises the error tokens and the end-of-text paths. Random texts built
// from well-formed token fragments, with byte noise mixed in, follow. Table
// tokens are compared with the table's own entries and random ones with a
// predictor of the lexer, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import stt_pkg::*;

  localparam int POS_BITS = 16;
  localparam logic [POS_BITS-1:0] POS_TOP = '1;
  localparam int MAX_TOKENS = 3;
  localparam int RANDOM_ITEMS = 130;

  typedef enum logic [3:0] {
    LX_IDLE, LX_DONE, LX_PAIR, LX_SLASH, LX_COMMENT, LX_WS,
    LX_LABEL, LX_NUMBER, LX_UNDEF, LX_CHAR, LX_STRING
  } lex_mode_t;

  typedef struct {
    logic [7:0]    b;
    logic          l;
    logic          e;
    int            n;
    result_t [2:0] exp;
  } stim_row_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [7:0]              text_byte;
  logic                    is_last;
  logic                    end_only;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [KIND_BITS-1:0]    token_kind;
  logic [OUT_POS_BITS-1:0] start_position;
  logic                    run_last;

  // lexer shadow state
  lex_mode_t         lx_mode;
  logic [5:0]        tok_kind;
  logic [15:0]       tok_start;
  logic [15:0]       byte_pos;
  logic              point_seen_q;
  logic              after_point;
  logic              escape_q;
  logic [1:0]        quote_phase;

  result_t           new_tokens [MAX_TOKENS];
  int                new_count;
  result_t           token_queue [$];
  result_t [2:0]     typed_tokens;
  int                typed_count;
  stim_row_t         stim_table [$];
  logic [7:0]        text_q [$];

  int burst_left;
  int stall_tick;
  int stall_mode;
  int items_sent;
  int texts_done;
  int tokens_checked;
  int mismatch_count;

  script_text_tokenizer_top #(
    .POS_BITS(POS_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .text_byte(text_byte),
    .is_last(is_last),
    .end_only(end_only),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .token_kind(token_kind),
    .start_position(start_position),
    .run_last(run_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("script_text_tokenizer_top: mismatch");
    $finish;
  end

  function automatic logic ws_char(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic alpha_char(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic label_char(input logic [7:0] c);
    return alpha_char(c) || digit_char(c) || (c == CH_UNDER);
  endfunction

  function automatic logic [7:0] alpha_pick();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  function automatic logic [7:0] digit_pick();
    return 8'($urandom_range("0", "9"));
  endfunction

  function automatic logic [7:0] ws_pick();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  task automatic clear_lexer();
    lx_mode = LX_IDLE;
    tok_kind = '0;
    tok_start = '0;
    byte_pos = '0;
    point_seen_q = 1'b0;
    after_point = 1'b0;
    escape_q = 1'b0;
    quote_phase = '0;
  endtask

  task automatic emit(input logic [5:0] kind, input logic [15:0] pos);
    if (new_count < MAX_TOKENS) begin
      new_tokens[new_count] = '{token_kind: kind, start_position: pos, run_last: 1'b0};
      new_count++;
    end
  endtask

  // Returns 1 when the open token takes the byte.
  function automatic logic extend_token(input logic [7:0] c);
    logic [7:0] want;
    case (lx_mode)
      LX_PAIR: begin
        want = (tok_kind == K_AMP) ? CH_AMP : (tok_kind == K_BAR) ? CH_BAR : CH_EQUALS;
        if (c != want) return 1'b0;
        case (tok_kind)
          K_BANG:   tok_kind = K_NE;
          K_ASSIGN: tok_kind = K_EQ;
          K_LT:     tok_kind = K_LE;
          K_GT:     tok_kind = K_GE;
          K_AMP:    tok_kind = K_ANDAND;
          default:  tok_kind = K_OROR;
        endcase
        lx_mode = LX_DONE;
        return 1'b1;
      end
      LX_SLASH: begin
        if (c != CH_SLASH) return 1'b0;
        tok_kind = K_COMMENT;
        lx_mode = LX_COMMENT;
        return 1'b1;
      end
      LX_COMMENT: return c != CH_LF;
      LX_WS:      return ws_char(c);
      LX_LABEL:   return label_char(c);
      LX_UNDEF:   return !ws_char(c);
      LX_NUMBER: begin
        if (c == CH_POINT) begin
          if (point_seen_q) begin
            tok_kind = K_UNDEF;
            lx_mode = LX_UNDEF;
          end else begin
            point_seen_q = 1'b1;
            after_point = 1'b1;
          end
          return 1'b1;
        end
        if (digit_char(c)) begin
          after_point = 1'b0;
          return 1'b1;
        end
        // anything but a digit straight after the point spoils the number, and is kept
        if (point_seen_q && after_point) begin
          tok_kind = K_UNDEF;
          lx_mode = LX_UNDEF;
          return 1'b1;
        end
        return 1'b0;
      end
      LX_CHAR: begin
        case (quote_phase)
          2'd1: quote_phase = (c == CH_BACKSLASH) ? 2'd2 : 2'd3;
          2'd2: quote_phase = 2'd3;
          default: begin
            tok_kind = (c == CH_QUOTE) ? K_CHARACTER : K_UNDEF;
            quote_phase = 2'd0;
            lx_mode = LX_DONE;
          end
        endcase
        return 1'b1;
      end
      LX_STRING: begin
        if (c == CH_DQUOTE) begin
          if (!escape_q) begin
            tok_kind = K_STRING;
            lx_mode = LX_DONE;
          end else begin
            escape_q = 1'b0;
          end
        end else if (c == CH_BACKSLASH) begin
          escape_q = ~escape_q;
        end else begin
          escape_q = 1'b0;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic start_token(input logic [7:0] c);
    tok_start = byte_pos;
    point_seen_q = 1'b0;
    after_point = 1'b0;
    escape_q = 1'b0;
    quote_phase = 2'd0;
    lx_mode = LX_DONE;
    case (c)
      "{":      tok_kind = K_LBRACE;
      "}":      tok_kind = K_RBRACE;
      "(":      tok_kind = K_LPAREN;
      ")":      tok_kind = K_RPAREN;
      "[":      tok_kind = K_LBRACKET;
      "]":      tok_kind = K_RBRACKET;
      ":":      tok_kind = K_COLON;
      ";":      tok_kind = K_SEMI;
      ",":      tok_kind = K_COMMA;
      "+":      tok_kind = K_PLUS;
      "-":      tok_kind = K_MINUS;
      "*":      tok_kind = K_STAR;
      CH_POINT: tok_kind = K_DOT;
      "?":      tok_kind = K_QUESTION;
      CH_EQUALS: begin tok_kind = K_ASSIGN; lx_mode = LX_PAIR; end
      "<":       begin tok_kind = K_LT;     lx_mode = LX_PAIR; end
      ">":       begin tok_kind = K_GT;     lx_mode = LX_PAIR; end
      CH_AMP:    begin tok_kind = K_AMP;    lx_mode = LX_PAIR; end
      CH_BAR:    begin tok_kind = K_BAR;    lx_mode = LX_PAIR; end
      "!":       begin tok_kind = K_BANG;   lx_mode = LX_PAIR; end
      CH_SLASH:  begin tok_kind = K_SLASH;  lx_mode = LX_SLASH; end
      CH_QUOTE: begin
        tok_kind = K_UNDEF;
        lx_mode = LX_CHAR;
        quote_phase = 2'd1;
      end
      CH_DQUOTE: begin tok_kind = K_UNDEF; lx_mode = LX_STRING; end
      default: begin
        if (alpha_char(c)) begin
          tok_kind = K_LABEL;
          lx_mode = LX_LABEL;
        end else if (ws_char(c)) begin
          tok_kind = K_WS;
          lx_mode = LX_WS;
        end else if (digit_char(c)) begin
          tok_kind = K_NUMBER;
          lx_mode = LX_NUMBER;
        end else begin
          tok_kind = K_UNDEF;
          lx_mode = LX_UNDEF;
        end
      end
    endcase
  endtask

  task automatic lex_item(input logic [7:0] c, input logic last, input logic eonly);
    new_count = 0;
    if (!eonly) begin
      if (!extend_token(c)) begin
        if (lx_mode != LX_IDLE) emit(tok_kind, tok_start);
        start_token(c);
      end
      if (byte_pos != POS_TOP) byte_pos++;
    end
    if (eonly || last) begin
      if (lx_mode != LX_IDLE) emit(tok_kind, tok_start);
      emit(K_END, byte_pos);
      clear_lexer();
    end
    if (new_count > 0) new_tokens[new_count-1].run_last = 1'b1;
  endtask

  // Drive one item, hold it until the transfer, then queue its tokens.
  task automatic send_item(input logic [7:0] b, input logic l, input logic e);
    result_t tk;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    text_byte <= b;
    is_last <= l;
    end_only <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_item(b, l, e);
    if (typed_count >= 0) begin
      for (int i = 0; i < typed_count; i++) begin
        tk = typed_tokens[i];
        tk.run_last = (i == typed_count - 1);
        token_queue.push_back(tk);
      end
    end else begin
      for (int i = 0; i < new_count; i++) token_queue.push_back(new_tokens[i]);
    end
    items_sent++;
  endtask

  task automatic add_row(input logic [7:0] b, input logic l, input logic e, input int n,
                         input logic [5:0] k0, input logic [15:0] p0,
                         input logic [5:0] k1, input logic [15:0] p1,
                         input logic [5:0] k2, input logic [15:0] p2);
    stim_row_t r;
    r.b = b;
    r.l = l;
    r.e = e;
    r.n = n;
    r.exp[0] = '{k0, p0, 1'b0};
    r.exp[1] = '{k1, p1, 1'b0};
    r.exp[2] = '{k2, p2, 1'b0};
    stim_table.push_back(r);
  endtask

  // receiver stall pattern, picked at random from four modes
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick % 3 != 0);
    endcase
  end

  always @(posedge clk) begin : check_tokens
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (token_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected token: kind %0d pos %0d last %0d",
                   token_kind, start_position, run_last);
      end else begin
        want = token_queue.pop_front();
        tokens_checked++;
        if (token_kind !== want.token_kind || start_position !== want.start_position ||
            run_last !== want.run_last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("token %0d: expected kind %0d pos %0d last %0d, got kind %0d pos %0d last %0d",
                     tokens_checked, want.token_kind, want.start_position, want.run_last,
                     token_kind, start_position, run_last);
        end
      end
    end
  end

  initial begin : stimulus
    string punct;
    string pairs;
    logic [7:0] c;
    int nfrag;
    int first_random;
    logic tail_only;

    punct = "{}()[]:;,+-*.?";
    pairs = "!=<>&|";
    rst <= 1'b1;
    in_valid <= 1'b0;
    text_byte <= '0;
    is_last <= 1'b0;
    end_only <= 1'b0;
    clear_lexer();
    burst_left = 0;
    typed_count = -1;
    stall_mode = 0;

    // empty text: byte and last flag are ignored
    add_row(8'hFF,        1, 1, 1, K_END, 0, K_WS, 0, K_WS, 0);
    add_row(8'h00,        0, 0, 0, K_WS, 0, K_WS, 0, K_WS, 0);
    add_row(8'hFF,        0, 0, 0, K_WS, 0, K_WS, 0, K_WS, 0);
    add_row(CH_SPACE,     0, 0, 1, K_UNDEF, 0, K_WS, 0, K_WS, 0);
    add_row("1",          0, 0, 1, K_WS, 2, K_WS, 0, K_WS, 0);
    add_row(CH_POINT,     0, 0, 0, K_WS, 0, K_WS, 0, K_WS, 0);
    // letter straight after the point
    add_row("a",          0, 0, 0, K_WS, 0, K_WS, 0, K_WS, 0);
    add_row(CH_TAB,       0, 0, 1, K_UNDEF, 3, K_WS, 0, K_WS, 0);
    add_row(CH_QUOTE,     0, 0, 1, K_WS, 6, K_WS, 0, K_WS, 0);
    add_row("q",          0, 0, 0, K_WS, 0, K_WS, 0, K_WS, 0);
    // quoted character without its closing quote
    add_row("z",          0, 0, 0, K_WS, 0, K_WS, 0, K_WS, 0);
    add_row(CH_DQUOTE,    0, 0, 1, K_UNDEF, 7, K_WS, 0, K_WS, 0);
    add_row(CH_BACKSLASH, 0, 0, 0, K_WS, 0, K_WS, 0, K_WS, 0);
    add_row(CH_DQUOTE,    0, 0, 0, K_WS, 0, K_WS, 0, K_WS, 0);
    // unterminated string closed by an end-only item
    add_row(8'h00,        0, 1, 2, K_UNDEF, 10, K_END, 13, K_WS, 0);
    add_row(CH_SLASH,     0, 0, 0, K_WS, 0, K_WS, 0, K_WS, 0);
    add_row(CH_SLASH,     0, 0, 0, K_WS, 0, K_WS, 0, K_WS, 0);
    add_row(CH_LF,        0, 0, 1, K_COMMENT, 0, K_WS, 0, K_WS, 0);
    add_row("9",          0, 0, 1, K_WS, 2, K_WS, 0, K_WS, 0);
    add_row(CH_POINT,     0, 0, 0, K_WS, 0, K_WS, 0, K_WS, 0);
    // second point
    add_row(CH_POINT,     0, 0, 0, K_WS, 0, K_WS, 0, K_WS, 0);
    add_row(CH_CR,        1, 0, 3, K_UNDEF, 3, K_WS, 6, K_END, 7);
    add_row(CH_QUOTE,     0, 0, 0, K_WS, 0, K_WS, 0, K_WS, 0);
    add_row(CH_BACKSLASH, 0, 0, 0, K_WS, 0, K_WS, 0, K_WS, 0);
    add_row(CH_QUOTE,     0, 0, 0, K_WS, 0, K_WS, 0, K_WS, 0);
    add_row(CH_QUOTE,     1, 0, 2, K_CHARACTER, 0, K_END, 4, K_WS, 0);
    // number ending in a point stays a number
    add_row("7",          0, 0, 0, K_WS, 0, K_WS, 0, K_WS, 0);
    add_row(CH_POINT,     1, 0, 2, K_NUMBER, 0, K_END, 2, K_WS, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      typed_count = stim_table[i].n;
      typed_tokens = stim_table[i].exp;
      send_item(stim_table[i].b, stim_table[i].l, stim_table[i].e);
    end
    typed_count = -1;
    texts_done = 5;

    first_random = items_sent;
    while (items_sent - first_random < RANDOM_ITEMS) begin
      text_q.delete();
      nfrag = $urandom_range(0, 10);
      repeat (nfrag) begin
        case ($urandom_range(0, 11))
          0: text_q.push_back(punct[$urandom_range(0, punct.len() - 1)]);
          1: begin
            c = pairs[$urandom_range(0, pairs.len() - 1)];
            text_q.push_back(c);
            if ($urandom_range(0, 3) != 0)
              text_q.push_back((c == CH_AMP) ? CH_AMP : (c == CH_BAR) ? CH_BAR : CH_EQUALS);
          end
          2, 9: begin
            text_q.push_back(alpha_pick());
            repeat ($urandom_range(0, 6)) begin
              case ($urandom_range(0, 2))
                0: text_q.push_back(alpha_pick());
                1: text_q.push_back(digit_pick());
                default: text_q.push_back(CH_UNDER);
              endcase
            end
          end
          3, 10: begin
            repeat ($urandom_range(1, 4)) text_q.push_back(digit_pick());
            case ($urandom_range(0, 5))
              1, 2: begin
                text_q.push_back(CH_POINT);
                repeat ($urandom_range(0, 3)) text_q.push_back(digit_pick());
              end
              3: text_q.push_back(CH_POINT);
              4: begin
                text_q.push_back(CH_POINT);
                text_q.push_back($urandom_range(0, 1) ? alpha_pick() : ws_pick());
              end
              5: begin
                text_q.push_back(CH_POINT);
                repeat ($urandom_range(0, 2)) text_q.push_back(digit_pick());
                text_q.push_back(CH_POINT);
              end
              default: ;
            endcase
          end
          4: begin
            text_q.push_back(CH_QUOTE);
            if ($urandom_range(0, 2) == 0) text_q.push_back(CH_BACKSLASH);
            text_q.push_back(8'($urandom_range(0, 255)));
            text_q.push_back(($urandom_range(0, 4) != 0) ? CH_QUOTE : 8'($urandom_range(0, 255)));
          end
          5: begin
            text_q.push_back(CH_DQUOTE);
            repeat ($urandom_range(0, 6)) begin
              case ($urandom_range(0, 3))
                0: text_q.push_back(alpha_pick());
                1: text_q.push_back(CH_BACKSLASH);
                2: begin
                  text_q.push_back(CH_BACKSLASH);
                  text_q.push_back(CH_DQUOTE);
                end
                default: text_q.push_back(8'($urandom_range(0, 255)));
              endcase
            end
            if ($urandom_range(0, 4) != 0) text_q.push_back(CH_DQUOTE);
          end
          6: begin
            text_q.push_back(CH_SLASH);
            text_q.push_back(CH_SLASH);
            repeat ($urandom_range(0, 8)) text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            if ($urandom_range(0, 9) != 0) text_q.push_back(CH_LF);
          end
          8: text_q.push_back(8'($urandom_range(0, 255)));
          default: repeat ($urandom_range(1, 3)) text_q.push_back(ws_pick());
        endcase
        if ($urandom_range(0, 1)) text_q.push_back(ws_pick());
      end
      // close either on the last byte or with a separate end-only item
      tail_only = (text_q.size() == 0) || ($urandom_range(0, 3) == 0);
      foreach (text_q[i])
        send_item(text_q[i], !tail_only && (i == text_q.size() - 1), 1'b0);
      if (tail_only) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      texts_done++;
    end
    in_valid <= 1'b0;

    while (token_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d texts in %0d transfers: table cases, then random token fragments",
             texts_done, items_sent);
    $display("%0d tokens compared, %0d mismatches", tokens_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("script_text_tokenizer_top: match");
    end else begin
      $display("script_text_tokenizer_top: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
design/stt_pkg.sv
design/stt_lexer.sv
design/stt_result_queue.sv
design/script_text_tokenizer_top.sv
test/tb_top.sv
